[sv/scc_irq_pkg.sv]
// ----------------------------------------------------------------------------
// scc_irq_pkg
// Types and constants shared by the serial controller interrupt register block.
// ----------------------------------------------------------------------------
package scc_irq_pkg;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_PINS  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    localparam logic [3:0] REG_0  = 4'd0;
    localparam logic [3:0] REG_1  = 4'd1;
    localparam logic [3:0] REG_2  = 4'd2;
    localparam logic [3:0] REG_3  = 4'd3;
    localparam logic [3:0] REG_9  = 4'd9;
    localparam logic [3:0] REG_15 = 4'd15;

    localparam logic [2:0] CMD_POINT_HIGH = 3'd1;

    localparam int unsigned IE_DCD_BIT   = 3;
    localparam int unsigned WR9_MIE_BIT  = 3;
    localparam int unsigned WR9_VIS_BIT  = 4;
    localparam int unsigned PEND_B_BIT   = 0;
    localparam int unsigned PEND_A_BIT   = 3;

    localparam logic [7:0] VEC_MASK_HIGH = 8'h8f;
    localparam logic [7:0] VEC_MASK_LOW  = 8'hf1;
    localparam logic [7:0] RR15_MASK     = 8'hfa;
    localparam logic [7:0] RR0_FIXED     = 8'h50;
    localparam logic [7:0] RR1_VALUE     = 8'h07;

    localparam logic [2:0] CODE_NONE  = 3'd0;
    localparam logic [2:0] CODE_B_EXT = 3'd1;
    localparam logic [2:0] CODE_A_EXT = 3'd5;

endpackage

[sv/scc_irq_if.sv]
// ----------------------------------------------------------------------------
// scc_irq_req_if / scc_irq_rsp_if
// Valid/ready channels carrying bus and pin items in, and results out.
// ----------------------------------------------------------------------------
interface scc_irq_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [2:0] address;
    logic [7:0] write_data;
    logic       pin_a;
    logic       pin_b;

    modport source (output valid, output operation, output address,
                    output write_data, output pin_a, output pin_b, input ready);
    modport sink   (input valid, input operation, input address,
                    input write_data, input pin_a, input pin_b, output ready);
endinterface

interface scc_irq_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       irq_line;

    modport source (output valid, output read_data, output irq_line, input ready);
    modport sink   (input valid, input read_data, input irq_line, output ready);
endinterface

[sv/serial_ctrl_dcd_interrupt_regs.sv]
// ----------------------------------------------------------------------------
// serial_ctrl_dcd_interrupt_regs
// Interrupt registers of a dual-channel serial controller, carrier-detect only.
//
//   channel   direction   contents
//   req       in          operation, address, write_data, pin_a, pin_b
//   rsp       out         read_data, irq_line
//
// An accepted item is held in the input register, then its result is written
// to the output register; one item is taken every cycle while rsp is not stalled.
// Valid flags and interrupt state are cleared by rst_n, the data registers
// are not. When rsp is stalled the input register holds until the output
// register frees, and req.ready drops only while both are full.
// ----------------------------------------------------------------------------
module serial_ctrl_dcd_interrupt_regs
(
    input  logic          clk,
    input  logic          rst_n,
    scc_irq_req_if.sink   req,
    scc_irq_rsp_if.source rsp
);

    logic       in_valid_reg;
    logic [1:0] in_op_reg;
    logic [2:0] in_addr_reg;
    logic [7:0] in_data_reg;
    logic       in_pin_a_reg;
    logic       in_pin_b_reg;

    logic       out_valid_reg;
    logic [7:0] out_rd_reg;

    logic [3:0] ptr_reg,      ptr_next;
    logic       mie_reg,      mie_next;
    logic       vis_reg,      vis_next;
    logic [7:0] ee_a_reg,     ee_a_next;
    logic [7:0] ee_b_reg,     ee_b_next;
    logic [3:0] pend_reg,     pend_next;
    logic [7:0] vec_reg,      vec_next;
    logic       irq_reg,      irq_next;
    logic [1:0] pins_reg,     pins_next;
    logic       chg_a_reg,    chg_a_next;
    logic       chg_b_reg,    chg_b_next;
    logic [7:0] rd_next;

    logic advance;
    logic chan_a;
    logic data_port;
    logic eval;
    logic [2:0] code;
    logic [1:0] new_pins;

    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || !out_valid_reg || rsp.ready;
    assign chan_a    = in_addr_reg[1];
    assign data_port = in_addr_reg[2];
    assign new_pins  = {in_pin_b_reg, in_pin_a_reg};

    always_comb
    begin
        ptr_next   = ptr_reg;
        mie_next   = mie_reg;
        vis_next   = vis_reg;
        ee_a_next  = ee_a_reg;
        ee_b_next  = ee_b_reg;
        pend_next  = pend_reg;
        vec_next   = vec_reg;
        irq_next   = irq_reg;
        pins_next  = pins_reg;
        chg_a_next = chg_a_reg;
        chg_b_next = chg_b_reg;
        rd_next    = 8'h00;
        eval       = 1'b0;
        code       = scc_irq_pkg::CODE_NONE;

        case (scc_irq_pkg::op_t'(in_op_reg))
            scc_irq_pkg::OP_WRITE:
            begin
                eval = 1'b1;
                if (!data_port)
                begin
                    ptr_next = scc_irq_pkg::REG_0;
                    case (ptr_reg)
                        scc_irq_pkg::REG_0:
                        begin
                            ptr_next = {in_data_reg[5:3] == scc_irq_pkg::CMD_POINT_HIGH,
                                        in_data_reg[2:0]};
                        end
                        scc_irq_pkg::REG_2:
                        begin
                            vec_next = in_data_reg;
                        end
                        scc_irq_pkg::REG_9:
                        begin
                            mie_next = in_data_reg[scc_irq_pkg::WR9_MIE_BIT];
                            vis_next = in_data_reg[scc_irq_pkg::WR9_VIS_BIT];
                        end
                        scc_irq_pkg::REG_15:
                        begin
                            if (chan_a)
                            begin
                                ee_a_next = in_data_reg;
                            end
                            else
                            begin
                                ee_b_next = in_data_reg;
                            end
                        end
                        default:
                        begin
                            ptr_next = scc_irq_pkg::REG_0;
                        end
                    endcase
                end
            end
            scc_irq_pkg::OP_READ:
            begin
                ptr_next = scc_irq_pkg::REG_0;
                if (!data_port)
                begin
                    case (ptr_reg)
                        scc_irq_pkg::REG_0:
                        begin
                            rd_next = scc_irq_pkg::RR0_FIXED
                                    | {4'b0000, (chan_a ? pins_reg[0] : pins_reg[1]), 3'b000};
                        end
                        scc_irq_pkg::REG_1:
                        begin
                            rd_next = scc_irq_pkg::RR1_VALUE;
                        end
                        scc_irq_pkg::REG_2:
                        begin
                            if (chan_a)
                            begin
                                rd_next = vec_reg;
                            end
                            else
                            begin
                                if (pend_reg[scc_irq_pkg::PEND_A_BIT])
                                begin
                                    code = scc_irq_pkg::CODE_A_EXT;
                                    pend_next[scc_irq_pkg::PEND_A_BIT] = 1'b0;
                                end
                                else if (pend_reg[scc_irq_pkg::PEND_B_BIT])
                                begin
                                    code = scc_irq_pkg::CODE_B_EXT;
                                    pend_next[scc_irq_pkg::PEND_B_BIT] = 1'b0;
                                end
                                if (vis_reg)
                                begin
                                    rd_next = (vec_reg & scc_irq_pkg::VEC_MASK_HIGH)
                                            | {1'b0, code, 4'b0000};
                                end
                                else
                                begin
                                    rd_next = (vec_reg & scc_irq_pkg::VEC_MASK_LOW)
                                            | {4'b0000, code, 1'b0};
                                end
                            end
                        end
                        scc_irq_pkg::REG_3:
                        begin
                            rd_next = chan_a ? {4'b0000, pend_reg} : 8'h00;
                        end
                        scc_irq_pkg::REG_15:
                        begin
                            rd_next = (chan_a ? ee_a_reg : ee_b_reg) & scc_irq_pkg::RR15_MASK;
                        end
                        default:
                        begin
                            rd_next = 8'h00;
                        end
                    endcase
                end
            end
            scc_irq_pkg::OP_PINS:
            begin
                eval       = 1'b1;
                chg_a_next = chg_a_reg | (new_pins[0] ^ pins_reg[0]);
                chg_b_next = chg_b_reg | (new_pins[1] ^ pins_reg[1]);
                pins_next  = new_pins;
            end
            default:
            begin
                eval = 1'b0;
            end
        endcase

        if (eval)
        begin
            if (chg_a_next && ee_a_next[scc_irq_pkg::IE_DCD_BIT])
            begin
                pend_next[scc_irq_pkg::PEND_A_BIT] = 1'b1;
                chg_a_next = 1'b0;
            end
            if (chg_b_next && ee_b_next[scc_irq_pkg::IE_DCD_BIT])
            begin
                pend_next[scc_irq_pkg::PEND_B_BIT] = 1'b1;
                chg_b_next = 1'b0;
            end
            irq_next = (pend_next != 4'b0000) && mie_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ptr_reg       <= '0;
            mie_reg       <= 1'b0;
            vis_reg       <= 1'b0;
            ee_a_reg      <= '0;
            ee_b_reg      <= '0;
            pend_reg      <= '0;
            vec_reg       <= '0;
            irq_reg       <= 1'b0;
            pins_reg      <= '0;
            chg_a_reg     <= 1'b0;
            chg_b_reg     <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                ptr_reg       <= ptr_next;
                mie_reg       <= mie_next;
                vis_reg       <= vis_next;
                ee_a_reg      <= ee_a_next;
                ee_b_reg      <= ee_b_next;
                pend_reg      <= pend_next;
                vec_reg       <= vec_next;
                irq_reg       <= irq_next;
                pins_reg      <= pins_next;
                chg_a_reg     <= chg_a_next;
                chg_b_reg     <= chg_b_next;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            in_op_reg    <= req.operation;
            in_addr_reg  <= req.address;
            in_data_reg  <= req.write_data;
            in_pin_a_reg <= req.pin_a;
            in_pin_b_reg <= req.pin_b;
        end
        if (advance)
        begin
            out_rd_reg <= rd_next;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = out_rd_reg;
    assign rsp.irq_line  = irq_reg;

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Checks the carrier-detect interrupt registers of the dual-channel serial
// controller. Bus writes, bus reads and pin events go in one item at a time.
// A local predictor tracks the pointer, enables, pending bits and vector. Each
// result is compared field by field with the oldest predicted result. Both
// sides of the block stall at random during most of the run.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_line;
    } scc_result_t;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam logic [3:0]  REG_UNLISTED = 4'd13;
    localparam logic [2:0]  ADDR_CHAN_A  = 3'b010;
    localparam logic [2:0]  ADDR_DATA    = 3'b100;

    logic clk = 1'b0;
    logic rst_n;

    scc_irq_req_if req ();
    scc_irq_rsp_if rsp ();

    serial_ctrl_dcd_interrupt_regs dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    logic [3:0] ptr    = '0;
    logic       mie    = 1'b0;
    logic       vis    = 1'b0;
    logic [7:0] ie [2] = '{8'h00, 8'h00};
    logic [3:0] pend   = '0;
    logic [7:0] vec    = '0;
    logic       irq    = 1'b0;
    logic [1:0] levels = '0;
    logic       chg_a  = 1'b0;
    logic       chg_b  = 1'b0;

    scc_result_t results_due [$];
    scc_result_t due;
    int unsigned errors     = 0;
    int unsigned items_sent = 0;
    int unsigned cycles     = 0;
    int unsigned stall_left = 0;
    bit          throttle   = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic scc_result_t scc_next_result(scc_irq_pkg::op_t op, logic [2:0] addr,
                                                    logic [7:0] wd, logic pa, logic pb);
        scc_result_t r;
        logic        chan;
        logic        lvl;
        logic [2:0]  code;
        chan = addr[1];
        r.read_data = 8'h00;
        case (op)
            scc_irq_pkg::OP_WRITE:
            begin
                if (!addr[2])
                begin
                    case (ptr)
                        scc_irq_pkg::REG_0:
                        begin
                            ptr = {wd[5:3] == scc_irq_pkg::CMD_POINT_HIGH, wd[2:0]};
                        end
                        scc_irq_pkg::REG_2:
                        begin
                            vec = wd;
                            ptr = scc_irq_pkg::REG_0;
                        end
                        scc_irq_pkg::REG_9:
                        begin
                            mie = wd[scc_irq_pkg::WR9_MIE_BIT];
                            vis = wd[scc_irq_pkg::WR9_VIS_BIT];
                            ptr = scc_irq_pkg::REG_0;
                        end
                        scc_irq_pkg::REG_15:
                        begin
                            ie[chan] = wd;
                            ptr = scc_irq_pkg::REG_0;
                        end
                        default:
                        begin
                            ptr = scc_irq_pkg::REG_0;
                        end
                    endcase
                end
            end
            scc_irq_pkg::OP_READ:
            begin
                if (!addr[2])
                begin
                    case (ptr)
                        scc_irq_pkg::REG_0:
                        begin
                            lvl = chan ? levels[0] : levels[1];
                            r.read_data = scc_irq_pkg::RR0_FIXED | {4'b0, lvl, 3'b0};
                        end
                        scc_irq_pkg::REG_1:
                        begin
                            r.read_data = scc_irq_pkg::RR1_VALUE;
                        end
                        scc_irq_pkg::REG_2:
                        begin
                            if (chan)
                            begin
                                r.read_data = vec;
                            end
                            else
                            begin
                                code = scc_irq_pkg::CODE_NONE;
                                if (pend[scc_irq_pkg::PEND_A_BIT])
                                begin
                                    code = scc_irq_pkg::CODE_A_EXT;
                                    pend[scc_irq_pkg::PEND_A_BIT] = 1'b0;
                                end
                                else if (pend[scc_irq_pkg::PEND_B_BIT])
                                begin
                                    code = scc_irq_pkg::CODE_B_EXT;
                                    pend[scc_irq_pkg::PEND_B_BIT] = 1'b0;
                                end
                                if (vis)
                                    r.read_data = (vec & scc_irq_pkg::VEC_MASK_HIGH)
                                                | {1'b0, code, 4'b0};
                                else
                                    r.read_data = (vec & scc_irq_pkg::VEC_MASK_LOW)
                                                | {4'b0, code, 1'b0};
                            end
                        end
                        scc_irq_pkg::REG_3:
                        begin
                            r.read_data = chan ? {4'b0, pend} : 8'h00;
                        end
                        scc_irq_pkg::REG_15:
                        begin
                            r.read_data = ie[chan] & scc_irq_pkg::RR15_MASK;
                        end
                        default:
                        begin
                            r.read_data = 8'h00;
                        end
                    endcase
                end
                ptr = scc_irq_pkg::REG_0;
            end
            scc_irq_pkg::OP_PINS:
            begin
                chg_a  = chg_a | (pa ^ levels[0]);
                chg_b  = chg_b | (pb ^ levels[1]);
                levels = {pb, pa};
            end
            default:
            begin
            end
        endcase
        if (op == scc_irq_pkg::OP_WRITE || op == scc_irq_pkg::OP_PINS)
        begin
            if (chg_a && ie[1][scc_irq_pkg::IE_DCD_BIT])
            begin
                pend[scc_irq_pkg::PEND_A_BIT] = 1'b1;
                chg_a = 1'b0;
            end
            if (chg_b && ie[0][scc_irq_pkg::IE_DCD_BIT])
            begin
                pend[scc_irq_pkg::PEND_B_BIT] = 1'b1;
                chg_b = 1'b0;
            end
            irq = (pend != 4'b0) && mie;
        end
        r.irq_line = irq;
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && req.valid && req.ready)
            results_due.push_back(scc_next_result(scc_irq_pkg::op_t'(req.operation),
                                                  req.address, req.write_data,
                                                  req.pin_a, req.pin_b));
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (results_due.size() == 0)
            begin
                $error("unexpected result: read_data=%02h irq_line=%0b",
                       rsp.read_data, rsp.irq_line);
                errors++;
            end
            else
            begin
                due = results_due.pop_front();
                if (rsp.read_data !== due.read_data)
                begin
                    $error("read_data: expected %02h, got %02h", due.read_data, rsp.read_data);
                    errors++;
                end
                if (rsp.irq_line !== due.irq_line)
                begin
                    $error("irq_line: expected %0b, got %0b", due.irq_line, rsp.irq_line);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic int unsigned gap_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 30);
        return $urandom_range(1, 3);
    endfunction

    initial
    begin
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                rsp.ready <= 1'b0;
                stall_left--;
            end
            else if (throttle && $urandom_range(0, 3) == 0)
            begin
                rsp.ready <= 1'b0;
                stall_left = gap_len() - 1;
            end
            else
            begin
                rsp.ready <= 1'b1;
            end
        end
    end

    task automatic send_item(scc_irq_pkg::op_t op, logic [2:0] addr, logic [7:0] wd,
                             logic pa, logic pb);
        int unsigned gap;
        gap = (throttle && $urandom_range(0, 2) == 0) ? gap_len() : 0;
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid      <= 1'b1;
        req.operation  <= op;
        req.address    <= addr;
        req.write_data <= wd;
        req.pin_a      <= pa;
        req.pin_b      <= pb;
        do
            @(posedge clk);
        while (!req.ready);
        items_sent++;
    endtask

    task automatic write_reg(logic chan, logic [3:0] regno, logic [7:0] value);
        logic [2:0] addr;
        addr    = {1'b0, chan, 1'b0};
        addr[0] = 1'($urandom_range(0, 1));
        send_item(scc_irq_pkg::OP_WRITE, addr,
                  {2'b00, (regno[3] ? scc_irq_pkg::CMD_POINT_HIGH : 3'd0), regno[2:0]},
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        send_item(scc_irq_pkg::OP_WRITE, addr, value,
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    task automatic read_reg(logic chan, logic [3:0] regno);
        logic [2:0] addr;
        addr    = {1'b0, chan, 1'b0};
        addr[0] = 1'($urandom_range(0, 1));
        send_item(scc_irq_pkg::OP_WRITE, addr,
                  {2'b00, (regno[3] ? scc_irq_pkg::CMD_POINT_HIGH : 3'd0), regno[2:0]},
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        send_item(scc_irq_pkg::OP_READ, addr, 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    task automatic drain_results();
        req.valid <= 1'b0;
        do
            @(posedge clk);
        while (results_due.size() != 0);
    endtask

    function automatic logic [3:0] pick_reg();
        logic [3:0] any;
        any = 4'($urandom_range(0, 15));
        case ($urandom_range(0, 7))
            0: return scc_irq_pkg::REG_0;
            1: return scc_irq_pkg::REG_1;
            2: return scc_irq_pkg::REG_2;
            3: return scc_irq_pkg::REG_3;
            4: return scc_irq_pkg::REG_9;
            5: return scc_irq_pkg::REG_15;
            default: return any;
        endcase
    endfunction

    task automatic test_register_map();
        throttle = 1'b0;
        write_reg(1'b1, scc_irq_pkg::REG_2, 8'hff);
        write_reg(1'b1, scc_irq_pkg::REG_15, 8'hff);
        write_reg(1'b0, scc_irq_pkg::REG_15, 8'h08);
        read_reg(1'b1, scc_irq_pkg::REG_15);
        read_reg(1'b1, REG_UNLISTED);
    endtask

    task automatic test_carrier_detect();
        write_reg(1'b0, scc_irq_pkg::REG_9, 8'h18);
        send_item(scc_irq_pkg::OP_PINS, 3'b000, 8'h00, 1'b1, 1'b1);
        read_reg(1'b1, scc_irq_pkg::REG_0);
        read_reg(1'b1, scc_irq_pkg::REG_3);
        read_reg(1'b0, scc_irq_pkg::REG_2);
        read_reg(1'b0, scc_irq_pkg::REG_2);
        read_reg(1'b0, scc_irq_pkg::REG_2);
        send_item(scc_irq_pkg::OP_WRITE, ADDR_DATA, 8'h00, 1'b1, 1'b1);
    endtask

    task automatic test_special_ops();
        send_item(scc_irq_pkg::OP_NONE, 3'b111, 8'hff, 1'b0, 1'b0);
        send_item(scc_irq_pkg::OP_READ, ADDR_DATA | ADDR_CHAN_A, 8'hff, 1'b1, 1'b1);
    endtask

    task automatic test_random_traffic(int unsigned count, bit stalls);
        int unsigned stop_at;
        throttle = stalls;
        stop_at  = items_sent + count;
        while (items_sent < stop_at)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                    write_reg(1'($urandom_range(0, 1)), pick_reg(),
                              8'($urandom_range(0, 255)));
                4, 5:
                    read_reg(1'($urandom_range(0, 1)), pick_reg());
                6, 7:
                    send_item(scc_irq_pkg::OP_PINS, 3'($urandom_range(0, 7)),
                              8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                8:
                    send_item(scc_irq_pkg::op_t'($urandom_range(0, 3)),
                              3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                default:
                    read_reg(1'b0, scc_irq_pkg::REG_2);
            endcase
        end
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        req.valid      <= 1'b0;
        req.operation  <= scc_irq_pkg::OP_NONE;
        req.address    <= 3'b000;
        req.write_data <= 8'h00;
        req.pin_a      <= 1'b0;
        req.pin_b      <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_map();
        test_carrier_detect();
        test_special_ops();
        test_random_traffic(200, 1'b1);
        test_random_traffic(100, 1'b0);
        drain_results();
        test_random_traffic(150, 1'b1);

        drain_results();
        repeat (4) @(posedge clk);
        if (errors == 0 && results_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
